/* rtl/perspective_world_to_screen_macros.svh */
// ----------------------------------------------------------------------------
// perspective_world_to_screen assertion macros
// Shared property forms for the projection pipeline checks.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH

// implication checked every cycle outside reset
`define PWTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset was high
`define PWTS_ASSERT_POST_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (cons)) else $error(msg);

`endif

/* rtl/pwts_pkg.sv */
// ----------------------------------------------------------------------------
// pwts_pkg
// Widths, register indices and shared types of the projection pipeline.
// ----------------------------------------------------------------------------
package pwts_pkg;

  localparam int CW  = 32;   // coefficient, Q15.16
  localparam int XW  = 24;   // world coordinate, Q15.8
  localparam int PRW = CW + XW;
  localparam int DW  = 58;   // dot product, Q.24
  localparam int HW  = DW / 2;
  localparam int MW  = 18;   // 8 * viewport size
  localparam int PLW = HW + MW;
  localparam int PW  = PLW + HW;
  localparam int QB  = 22;   // quotient bits below the clamp
  localparam int SW  = 20;   // screen coordinate, Q15.4
  localparam int OW  = 25;   // centre plus offset before saturation
  localparam int VW  = 15;   // viewport register width
  localparam int AW  = 6;

  localparam logic signed [DW-1:0] W_THRESH = DW'(16778);
  localparam logic signed [SW-1:0] OUT_MAX  = SW'(524287);
  localparam logic signed [SW-1:0] OUT_MIN  = SW'(-524288);

  localparam logic [2:0] REG_ROW0_LO = 3'd0;
  localparam logic [2:0] REG_ROW0_HI = 3'd1;
  localparam logic [2:0] REG_ROW1_LO = 3'd2;
  localparam logic [2:0] REG_ROW1_HI = 3'd3;
  localparam logic [2:0] REG_ROW3_LO = 3'd4;
  localparam logic [2:0] REG_ROW3_HI = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  localparam logic [VW-1:0] WIDTH_RST  = VW'(1920);
  localparam logic [VW-1:0] HEIGHT_RST = VW'(1080);

  // coef[r][c]: r = 0, 1, 2 for matrix rows 0, 1, 3
  typedef struct packed {
    logic [2:0][3:0][CW-1:0] coef;
    logic [VW-1:0]           width;
    logic [VW-1:0]           height;
  } cfg_t;

  typedef struct packed {
    logic vis;
    logic neg;
  } tag_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

endpackage

/* rtl/pwts_regs.sv */
// ----------------------------------------------------------------------------
// pwts_regs
// Configuration register file on the APB-style port.
// ----------------------------------------------------------------------------
module pwts_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [pwts_pkg::AW-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output pwts_pkg::cfg_t       cfg
);
  import pwts_pkg::*;

  logic [5:0][63:0] rg;
  logic [VW-1:0]    width;
  logic [VW-1:0]    height;
  logic [2:0]       idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rg     <= '0;
      width  <= WIDTH_RST;
      height <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ROW0_LO: rg[0] <= pwdata;
        REG_ROW0_HI: rg[1] <= pwdata;
        REG_ROW1_LO: rg[2] <= pwdata;
        REG_ROW1_HI: rg[3] <= pwdata;
        REG_ROW3_LO: rg[4] <= pwdata;
        REG_ROW3_HI: rg[5] <= pwdata;
        REG_WIDTH:   width  <= pwdata[VW-1:0];
        REG_HEIGHT:  height <= pwdata[VW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW0_LO: prdata = rg[0];
      REG_ROW0_HI: prdata = rg[1];
      REG_ROW1_LO: prdata = rg[2];
      REG_ROW1_HI: prdata = rg[3];
      REG_ROW3_LO: prdata = rg[4];
      REG_ROW3_HI: prdata = rg[5];
      REG_WIDTH:   prdata = 64'(width);
      REG_HEIGHT:  prdata = 64'(height);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cfg.coef[r][0] = rg[2*r][31:0];
      cfg.coef[r][1] = rg[2*r][63:32];
      cfg.coef[r][2] = rg[2*r+1][31:0];
      cfg.coef[r][3] = rg[2*r+1][63:32];
    end
    cfg.width  = width;
    cfg.height = height;
  end

endmodule

/* rtl/pwts_dot.sv */
// ----------------------------------------------------------------------------
// pwts_dot
// Three row dot products in two stages: multiply, then sum with translation.
// ----------------------------------------------------------------------------
module pwts_dot (
  input  logic                          clk,
  input  logic                          rst,
  input  pwts_pkg::pipe_ctl_t           ctl,
  input  logic                          in_valid,
  input  logic signed [pwts_pkg::XW-1:0] x,
  input  logic signed [pwts_pkg::XW-1:0] y,
  input  logic signed [pwts_pkg::XW-1:0] z,
  input  pwts_pkg::cfg_t                cfg,
  output logic                          out_valid,
  output logic signed [pwts_pkg::DW-1:0] dot [3]
);
  import pwts_pkg::*;

  logic signed [PRW-1:0] prod [3][3];
  logic signed [CW-1:0]  trans [3];
  logic                  v1;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= $signed(cfg.coef[r][0]) * x;
        prod[r][1] <= $signed(cfg.coef[r][1]) * y;
        prod[r][2] <= $signed(cfg.coef[r][2]) * z;
        trans[r]   <= $signed(cfg.coef[r][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int r = 0; r < 3; r++) begin
        dot[r] <= DW'(prod[r][0]) + DW'(prod[r][1]) + DW'(prod[r][2])
                + (DW'(trans[r]) <<< 8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/pwts_div.sv */
// ----------------------------------------------------------------------------
// pwts_div
// Pipelined scaled divide: min(trunc(|n| * m / w), 2^22), one quotient bit
// per stage after a split multiply and a clamp compare.
// ----------------------------------------------------------------------------
module pwts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  pwts_pkg::pipe_ctl_t           ctl,
  input  logic                          in_valid,
  input  logic signed [pwts_pkg::DW-1:0] n,
  input  logic [pwts_pkg::DW-1:0]       w,
  input  logic [pwts_pkg::MW-1:0]       m,
  input  pwts_pkg::tag_t                tag_in,
  output logic                          out_valid,
  output logic [pwts_pkg::QB:0]         q,
  output pwts_pkg::tag_t                tag_out
);
  import pwts_pkg::*;

  // stage A: magnitude
  logic [DW-1:0]  a_a, w_a;
  logic [MW-1:0]  m_a;
  tag_t           t_a;
  logic           v_a;
  // stage B: partial products
  logic [PLW-1:0] plo_b, phi_b;
  logic [DW-1:0]  w_b;
  tag_t           t_b;
  logic           v_b;
  // stage C: full product
  logic [PW-1:0]  p_c;
  logic [DW-1:0]  w_c;
  tag_t           t_c;
  logic           v_c;
  // division steps, index 0 is the clamp stage
  logic [DW-1:0]  rem  [QB+1];
  logic [QB-1:0]  low  [QB+1];
  logic [QB-1:0]  qb   [QB+1];
  logic [DW-1:0]  wp   [QB+1];
  tag_t           tg   [QB+1];
  logic           sat  [QB+1];
  logic           vld  [QB+1];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_a   <= n[DW-1] ? DW'(-n) : DW'(n);
      w_a   <= w;
      m_a   <= m;
      t_a   <= tag_in;
      plo_b <= PLW'(a_a[HW-1:0]) * PLW'(m_a);
      phi_b <= PLW'(a_a[DW-1:HW]) * PLW'(m_a);
      w_b   <= w_a;
      t_b   <= t_a;
      p_c   <= {phi_b, {HW{1'b0}}} + PW'(plo_b);
      w_c   <= w_b;
      t_c   <= t_b;
      // quotient reaches the clamp when product >= w * 2^22
      sat[0] <= {4'b0, p_c} >= {w_c, {QB{1'b0}}};
      rem[0] <= DW'(p_c[PW-1:QB]);
      low[0] <= p_c[QB-1:0];
      qb[0]  <= '0;
      wp[0]  <= w_c;
      tg[0]  <= t_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a    <= 1'b0;
      v_b    <= 1'b0;
      v_c    <= 1'b0;
      vld[0] <= 1'b0;
    end else if (ctl.en) begin
      v_a    <= in_valid;
      v_b    <= v_a;
      v_c    <= v_b;
      vld[0] <= v_c;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem[i], low[i][QB-1]};
    assign ge = t >= {1'b0, wp[i]};

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[i+1] <= ge ? DW'(t - {1'b0, wp[i]}) : t[DW-1:0];
        low[i+1] <= low[i] << 1;
        qb[i+1]  <= {qb[i][QB-2:0], ge};
        wp[i+1]  <= wp[i];
        tg[i+1]  <= tg[i];
        sat[i+1] <= sat[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ctl.en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[QB];
  assign tag_out   = tg[QB];
  assign q         = sat[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, qb[QB]};

endmodule

/* rtl/perspective_world_to_screen.sv */
// ----------------------------------------------------------------------------
// perspective_world_to_screen
// Projects world points to viewport pixels through a configured matrix.
// ----------------------------------------------------------------------------
// Use: program the three matrix rows and the viewport size over the APB port
// while the stream is idle, then push world points on the s_ side.
// Each accepted item gives exactly one result item on the m_ side:
// screen x and y in tdata, the visible flag in tuser.
// Items pass the dot products, then magnitude, scaling and clamp compare,
// then the divider (one quotient bit per stage) and the output register.
// Throughput is one item per cycle while the output is not stalled; the
// 22-stage divider pair sets the depth.
// Reset clears all valid bits and loads the register defaults (zero matrix,
// 1920 x 1080 viewport). When m_tready is low with a result waiting, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module perspective_world_to_screen (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // world_x, world_y, world_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // screen_x, screen_y
  output logic [0:0]  m_tuser    // visible
);
  import pwts_pkg::*;

  `include "perspective_world_to_screen_macros.svh"

  cfg_t                  cfg;
  pipe_ctl_t             ctl;
  logic                  dot_valid;
  logic signed [DW-1:0]  dot [3];
  logic [MW-1:0]         mx, my;
  tag_t                  tag_x, tag_y, tag_xo, tag_yo;
  logic                  vx, vy;
  logic [QB:0]           qx, qy;
  logic signed [OW-1:0]  sum_x, sum_y;
  logic signed [SW-1:0]  sat_x, sat_y;

  assign ctl.en   = !m_tvalid || m_tready;
  assign s_tready = ctl.en;

  pwts_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pwts_dot u_dot (
    .clk, .rst, .ctl,
    .in_valid  (s_tvalid),
    .x         (s_tdata[23:0]),
    .y         (s_tdata[47:24]),
    .z         (s_tdata[71:48]),
    .cfg,
    .out_valid (dot_valid),
    .dot
  );

  assign mx = {cfg.width, 3'b0};
  assign my = {cfg.height, 3'b0};
  assign tag_x.vis = dot[2] >= W_THRESH;
  assign tag_x.neg = dot[0][DW-1];
  assign tag_y.vis = tag_x.vis;
  assign tag_y.neg = dot[1][DW-1];

  pwts_div u_div_x (
    .clk, .rst, .ctl,
    .in_valid (dot_valid), .n (dot[0]), .w (dot[2]), .m (mx), .tag_in (tag_x),
    .out_valid (vx), .q (qx), .tag_out (tag_xo)
  );

  pwts_div u_div_y (
    .clk, .rst, .ctl,
    .in_valid (dot_valid), .n (dot[1]), .w (dot[2]), .m (my), .tag_in (tag_y),
    .out_valid (vy), .q (qy), .tag_out (tag_yo)
  );

  // centre plus or minus the signed offset, saturated to the screen range
  always_comb begin
    logic signed [OW-1:0] ox, oy;
    ox = tag_xo.neg ? -OW'(qx) : OW'(qx);
    oy = tag_yo.neg ? -OW'(qy) : OW'(qy);
    sum_x = OW'({cfg.width, 3'b0}) + ox;
    sum_y = OW'({cfg.height, 3'b0}) - oy;
    if (sum_x > OW'(OUT_MAX))      sat_x = OUT_MAX;
    else if (sum_x < OW'(OUT_MIN)) sat_x = OUT_MIN;
    else                           sat_x = sum_x[SW-1:0];
    if (sum_y > OW'(OUT_MAX))      sat_y = OUT_MAX;
    else if (sum_y < OW'(OUT_MIN)) sat_y = OUT_MIN;
    else                           sat_y = sum_y[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      m_tuser <= tag_xo.vis;
      m_tdata <= tag_xo.vis ? {sat_y, sat_x} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.en) begin
      m_tvalid <= vx;
    end
  end

  `PWTS_ASSERT_IMP(a_hidden_zero, m_tvalid && !m_tuser[0], m_tdata == '0,
    "hidden point with nonzero coordinates")
  `PWTS_ASSERT_IMP(a_lanes_aligned, 1'b1, vx == vy && (!vx || tag_xo.vis == tag_yo.vis),
    "x and y divider lanes out of step")
  `PWTS_ASSERT_IMP(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready),
    "input ready does not follow output stall")
  `PWTS_ASSERT_POST_RESET(a_reset_empty, !m_tvalid, "result valid straight after reset")

endmodule
